>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the environment key/value extractor.
// Needs nothing else; each macro compiles away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed: forbidden condition seen");
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ekv_pkg.sv
// Shared types, constants and helper functions of the environment key/value extractor.
// Depends on nothing; imported by ekv_out_if, ekv_parser, ekv_drain and the top level.
`default_nettype none
package ekv_pkg;

	// Size of the value output buffer; the value memory holds one entry less.
	localparam int VALUE_CAPACITY = 64;
	localparam int BUF_DEPTH      = VALUE_CAPACITY - 1;
	localparam int BUF_AW         = $clog2(BUF_DEPTH);
	localparam int CAP_W          = 7;
	localparam int LEN_W          = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(VALUE_CAPACITY);

	// Key "hw_rev=" is seven bytes long.
	localparam logic [2:0] KEY_LEN = 3'd7;

	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	typedef enum logic [1:0] {
		ST_VALUE     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	// Write into the value memory.
	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

	// Request from the parser to the drain: a single status or a burst of values.
	typedef struct packed {
		logic             valid;
		logic             values;
		status_t          status;
		logic [LEN_W-1:0] count;
	} burst_req_t;

	function automatic logic [7:0] key_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0:    b = 8'h68; // h
			3'd1:    b = 8'h77; // w
			3'd2:    b = 8'h5F; // _
			3'd3:    b = 8'h72; // r
			3'd4:    b = 8'h65; // e
			3'd5:    b = 8'h76; // v
			3'd6:    b = 8'h3D; // =
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] lower_byte(input logic [7:0] b);
		logic [7:0] r;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			r = b - CHAR_UPPER_A + CHAR_LOWER_A;
		end else begin
			r = b;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ekv_in_if.sv
// Input channel of the environment key/value extractor: one environment byte per request.
// Depends on nothing.
`default_nettype none
interface ekv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] env_byte;
	logic       final_byte;

	modport source (output valid, output env_byte, output final_byte, input ready);
	modport sink (input valid, input env_byte, input final_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/ekv_out_if.sv
// Result channel of the environment key/value extractor: one value byte or status per request.
// Depends on ekv_pkg for the status type.
`default_nettype none
interface ekv_out_if import ekv_pkg::*; ;
	logic             valid;
	logic             ready;
	status_t          status;
	logic [7:0]       value_char;
	logic [LEN_W-1:0] value_length;
	logic             last_result;

	modport source (output valid, output status, output value_char, output value_length,
		output last_result, input ready);
	modport sink (input valid, input status, input value_char, input value_length,
		input last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/ekv_parser.sv
// Entry parser: matches the key, counts and lower-cases value bytes, decides the outcome.
// Depends on ekv_pkg; writes the value memory held in ekv_drain.
`default_nettype none
module ekv_parser import ekv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [7:0]       env_byte,
	input  wire logic             final_byte,
	input  wire logic [CAP_W-1:0] value_capacity,
	output buf_wr_t               buf_wr,
	output burst_req_t            burst_req
);

	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_MATCH = 5'b00010,
		PH_SKIP  = 5'b00100,
		PH_VALUE = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t     ph;
		burst_req_t req;
	} finish_t;

	phase_t           phase_q, ph_n;
	logic [2:0]       key_pos_q, kp_n;
	logic [CAP_W-1:0] value_count_q, vc_n;
	logic [CAP_W-1:0] cap_eff;
	finish_t          fin_r;

	assign cap_eff = (value_capacity > CAP_W'(VALUE_CAPACITY)) ?
		CAP_W'(VALUE_CAPACITY) : value_capacity;

	// End of the matched entry: an empty value keeps searching, otherwise report.
	function automatic finish_t finish_value(input logic [CAP_W-1:0] vc,
		input logic [CAP_W-1:0] cap);
		finish_t f;
		f = '0;
		if (vc == '0) begin
			f.ph = PH_START;
		end else if (({1'b0, vc} + (CAP_W+1)'(1)) > {1'b0, cap}) begin
			f.ph         = PH_DONE;
			f.req.valid  = 1'b1;
			f.req.status = ST_TOO_LONG;
		end else begin
			f.ph         = PH_DONE;
			f.req.valid  = 1'b1;
			f.req.values = 1'b1;
			f.req.status = ST_VALUE;
			f.req.count  = vc[LEN_W-1:0];
		end
		return f;
	endfunction

	always_comb begin
		ph_n      = phase_q;
		kp_n      = key_pos_q;
		vc_n      = value_count_q;
		buf_wr    = '0;
		burst_req = '0;
		fin_r     = '0;
		if (fire) begin
			if (ph_n == PH_START) begin
				if (env_byte == CHAR_NUL) begin
					burst_req.valid  = 1'b1;
					burst_req.status = ST_NOT_FOUND;
					ph_n             = PH_DONE;
				end else begin
					ph_n = PH_MATCH;
					kp_n = '0;
				end
			end
			if (!burst_req.valid) begin
				case (ph_n)
					PH_MATCH: begin
						if (env_byte == CHAR_NUL) begin
							ph_n = PH_START;
						end else if (kp_n < KEY_LEN && env_byte == key_byte(kp_n)) begin
							kp_n = kp_n + 3'd1;
							if (kp_n == KEY_LEN) begin
								ph_n = PH_VALUE;
								vc_n = '0;
							end
						end else begin
							ph_n = PH_SKIP;
						end
					end
					PH_SKIP: begin
						if (env_byte == CHAR_NUL) begin
							ph_n = PH_START;
						end
					end
					PH_VALUE: begin
						if (env_byte == CHAR_NUL) begin
							fin_r     = finish_value(vc_n, cap_eff);
							ph_n      = fin_r.ph;
							burst_req = fin_r.req;
						end else if (vc_n < CAP_W'(VALUE_CAPACITY)) begin
							if (vc_n < CAP_W'(BUF_DEPTH)) begin
								buf_wr.en   = 1'b1;
								buf_wr.addr = vc_n[BUF_AW-1:0];
								buf_wr.data = lower_byte(env_byte);
							end
							vc_n = vc_n + CAP_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (final_byte) begin
				if (ph_n == PH_VALUE) begin
					fin_r     = finish_value(vc_n, cap_eff);
					ph_n      = fin_r.ph;
					burst_req = fin_r.req;
				end
				if (ph_n != PH_DONE) begin
					burst_req        = '0;
					burst_req.valid  = 1'b1;
					burst_req.status = ST_NOT_FOUND;
				end
				ph_n = PH_START;
				kp_n = '0;
				vc_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			key_pos_q     <= '0;
			value_count_q <= '0;
		end else begin
			phase_q       <= ph_n;
			key_pos_q     <= kp_n;
			value_count_q <= vc_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ekv_drain.sv
// Value memory and result sequencer: replays buffered value bytes or sends a status result.
// Depends on ekv_pkg and ekv_out_if; fed by ekv_parser.
`default_nettype none
module ekv_drain import ekv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire buf_wr_t    buf_wr,
	input  wire burst_req_t burst_req,
	output logic            idle,
	ekv_out_if.source       result_out
);

	logic [7:0]        mem [BUF_DEPTH];
	logic [7:0]        rd_data_q;
	logic              active_q;
	logic [BUF_AW-1:0] rd_ptr_q;
	logic [LEN_W-1:0]  count_q;
	logic              valid_s1, last_s1;
	logic              out_free, s1_move, issue, issue_last;

	assign out_free   = !result_out.valid || result_out.ready;
	assign s1_move    = valid_s1 && out_free;
	assign issue      = active_q && (!valid_s1 || s1_move);
	assign issue_last = LEN_W'(rd_ptr_q) == count_q - LEN_W'(1);
	// New requests are taken only with nothing in flight and the result slot free.
	assign idle       = !active_q && !valid_s1 && out_free;

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[buf_wr.addr] <= buf_wr.data;
		end
		if (issue) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q         <= 1'b0;
			valid_s1         <= 1'b0;
			result_out.valid <= 1'b0;
		end else begin
			if (burst_req.valid && burst_req.values) begin
				active_q <= 1'b1;
			end else if (issue && issue_last) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move || (burst_req.valid && !burst_req.values)) begin
				result_out.valid <= 1'b1;
			end else if (result_out.ready) begin
				result_out.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_req.valid && burst_req.values) begin
			rd_ptr_q <= '0;
			count_q  <= burst_req.count;
		end else if (issue) begin
			rd_ptr_q <= rd_ptr_q + BUF_AW'(1);
		end
		if (issue) begin
			last_s1 <= issue_last;
		end
		if (s1_move) begin
			result_out.status       <= ST_VALUE;
			result_out.value_char   <= rd_data_q;
			result_out.value_length <= count_q;
			result_out.last_result  <= last_s1;
		end else if (burst_req.valid && !burst_req.values) begin
			result_out.status       <= burst_req.status;
			result_out.value_char   <= '0;
			result_out.value_length <= '0;
			result_out.last_result  <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/env_block_key_value_extractor.sv
// Environment block key/value extractor. Bytes of a NUL-separated key=value environment
// block are taken one per cycle on env_in while env_in.ready is high, with final_byte
// marking the block's last byte. The first entry that begins with hw_rev= and carries at
// least one value byte is captured, lower-cased, into a 63-entry value memory; when that
// entry ends, the value is replayed on result_out one byte per cycle while the sink is
// ready, with last_result on its last byte, or a single "value too long" status is sent
// if the length plus one exceeds value_capacity (capped at 64). If the block ends before
// a match, a single "key not found" status is sent. While scanning, one byte is accepted
// every cycle once any earlier result has been taken. After a matched entry ends, input
// is held off while the memory, with its registered read, streams the value through a
// read stage into the output register, and longer while the sink stalls. A status
// result costs no stall beyond the output register being taken.
// The memory needs no clearing after reset, since only bytes written in the current run
// are read back. value_capacity is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module env_block_key_value_extractor import ekv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data,
	ekv_in_if.sink                env_in,
	ekv_out_if.source             result_out
);

	logic [CAP_W-1:0] value_capacity_q;
	logic             drain_idle;
	logic             in_fire;
	buf_wr_t          buf_wr;
	burst_req_t       burst_req;

	// The capacity register resets to the full buffer size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			value_capacity_q <= cfg_wr_data;
		end
	end

	// A request is taken only when the drain can absorb whatever it may trigger, so
	// the parser never writes the memory while a value is being replayed.
	assign env_in.ready = drain_idle;
	assign in_fire      = env_in.valid && env_in.ready;

	ekv_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (in_fire),
		.env_byte       (env_in.env_byte),
		.final_byte     (env_in.final_byte),
		.value_capacity (value_capacity_q),
		.buf_wr         (buf_wr),
		.burst_req      (burst_req)
	);

	ekv_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.buf_wr     (buf_wr),
		.burst_req  (burst_req),
		.idle       (drain_idle),
		.result_out (result_out)
	);

	// Value bytes are only ever written inside the value memory.
	`ASSERT_IMPLIES(a_wr_in_range, clk, arst_n, buf_wr.en, buf_wr.addr < BUF_AW'(BUF_DEPTH))
	// Parser activity only follows an accepted request.
	`ASSERT_IMPLIES(a_req_needs_fire, clk, arst_n, burst_req.valid || buf_wr.en, in_fire)
	// A status result is always a one-item run with zero length.
	`ASSERT_IMPLIES(a_status_shape, clk, arst_n,
		result_out.valid && result_out.status != ST_VALUE,
		result_out.last_result && result_out.value_length == '0)

endmodule
`default_nettype wire
